// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the date to epoch RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Signal is low in the cycle after a reset edge.
`define ASSERT_RESET_CLEARS(label, clk, rstn, sig) \
    label: assert property (@(posedge clk) !(rstn) |=> !(sig)) \
        else $error("reset did not clear signal");

`endif

// ----- hw/rtl/cdem_pkg.sv -----
// Package for the calendar date to epoch milliseconds unit.
// Field widths, constants, command/status structs and table functions; no dependencies.
`timescale 1ns / 1ps

package cdem_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int EPOCH_W  = 43;

    localparam int BASE_YEAR   = 1970;
    localparam int YEAR_MAX    = (1 << YEAR_W) - 1;
    localparam int LEAP_CYCLE  = 400;
    localparam int DAYS_LEAP   = 366;
    localparam int DAYS_COMMON = 365;

    localparam logic [8:0] BASE_MOD400 = 9'(BASE_YEAR % LEAP_CYCLE);
    localparam logic [8:0] MOD400_LAST = 9'(LEAP_CYCLE - 1);

    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
    localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
    localparam logic [26:0] MS_PER_MIN  = 27'd60000;
    localparam logic [26:0] MS_PER_SEC  = 27'd1000;

    typedef enum logic [1:0] {
        SC_DAY  = 2'd0,
        SC_HOUR = 2'd1,
        SC_MIN  = 2'd2,
        SC_SEC  = 2'd3
    } scale_sel_t;

    typedef struct packed {
        logic       load;
        logic       leap_step;
        logic       year_step;
        logic       month_step;
        logic       scale_step;
        scale_sel_t scale_sel;
        logic       finish;
    } dp_cmd_t;

    typedef struct packed {
        logic leap_done;
        logic years_done;
        logic months_done;
        logic out_free;
    } dp_status_t;

    // r is year mod 400
    function automatic logic leap_from_mod400(input logic [8:0] r);
        return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/cdem_ctrl.sv -----
// Sequencer for the date to epoch unit: leap reduction, year loop, month loop, scaling.
// Depends on cdem_pkg; drives the datapath through dp_cmd_t, reads dp_status_t.
`timescale 1ns / 1ps

module cdem_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  cdem_pkg::dp_status_t  status,
    output cdem_pkg::dp_cmd_t     cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LEAP   = 6'b000010,
        ST_YEARS  = 6'b000100,
        ST_MONTHS = 6'b001000,
        ST_SCALE  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    cdem_pkg::scale_sel_t   sc_reg, sc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sc_reg    <= cdem_pkg::SC_DAY;
        end else begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        sc_next       = sc_reg;
        cmd           = '0;
        cmd.scale_sel = sc_reg;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    sc_next    = cdem_pkg::SC_DAY;
                    state_next = ST_LEAP;
                end
            end
            ST_LEAP: begin
                if (status.leap_done) begin
                    state_next = ST_YEARS;
                end else begin
                    cmd.leap_step = 1'b1;
                end
            end
            ST_YEARS: begin
                if (status.years_done) begin
                    state_next = ST_MONTHS;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTHS: begin
                if (status.months_done) begin
                    state_next = ST_SCALE;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_SCALE: begin
                cmd.scale_step = 1'b1;
                unique case (sc_reg)
                    cdem_pkg::SC_DAY:  sc_next = cdem_pkg::SC_HOUR;
                    cdem_pkg::SC_HOUR: sc_next = cdem_pkg::SC_MIN;
                    cdem_pkg::SC_MIN:  sc_next = cdem_pkg::SC_SEC;
                    cdem_pkg::SC_SEC: begin
                        sc_next    = cdem_pkg::SC_DAY;
                        state_next = ST_DONE;
                    end
                    default: sc_next = cdem_pkg::SC_DAY;
                endcase
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/cdem_dp.sv -----
// Datapath for the date to epoch unit: day accumulator, mod-400 counters, one shared
// multiplier with accumulator, and the output register. Depends on cdem_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdem_dp #(
    parameter int LAST_YEAR = 2225
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [cdem_pkg::YEAR_W-1:0]          s_year,
    input  logic [cdem_pkg::MONTH_W-1:0]         s_month,
    input  logic [cdem_pkg::DAY_W-1:0]           s_day,
    input  logic [cdem_pkg::HOUR_W-1:0]          s_hour,
    input  logic [cdem_pkg::MINUTE_W-1:0]        s_minute,
    input  logic [cdem_pkg::SECOND_W-1:0]        s_second,
    input  cdem_pkg::dp_cmd_t                    cmd,
    output cdem_pkg::dp_status_t                 status,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [cdem_pkg::EPOCH_W-1:0]         m_epoch_ms
);

    localparam int YEAR_CAP = (LAST_YEAR > cdem_pkg::YEAR_MAX) ? cdem_pkg::YEAR_MAX : LAST_YEAR;
    localparam longint MAX_DAYS =
        longint'(YEAR_CAP - cdem_pkg::BASE_YEAR + 1) * longint'(cdem_pkg::DAYS_LEAP)
        + longint'((1 << cdem_pkg::DAY_W) - 1);
    localparam int DAYS_W = $clog2(MAX_DAYS + 1);
    localparam longint MAX_MS =
        MAX_DAYS * longint'(cdem_pkg::MS_PER_DAY)
        + longint'((1 << cdem_pkg::HOUR_W) - 1) * longint'(cdem_pkg::MS_PER_HOUR)
        + longint'((1 << cdem_pkg::MINUTE_W) - 1) * longint'(cdem_pkg::MS_PER_MIN)
        + longint'((1 << cdem_pkg::SECOND_W) - 1) * longint'(cdem_pkg::MS_PER_SEC);
    localparam int ACC_W = $clog2(MAX_MS + 1);

    localparam logic [cdem_pkg::YEAR_W-1:0] YEAR_CAP_V  = cdem_pkg::YEAR_W'(YEAR_CAP);
    localparam logic [cdem_pkg::YEAR_W-1:0] BASE_YEAR_V = cdem_pkg::YEAR_W'(cdem_pkg::BASE_YEAR);
    localparam logic [cdem_pkg::YEAR_W-1:0] CYCLE_V     = cdem_pkg::YEAR_W'(cdem_pkg::LEAP_CYCLE);

    logic [cdem_pkg::YEAR_W-1:0]    year_reg, r_reg, y_reg;
    logic [8:0]                     c400_reg;
    logic [cdem_pkg::MONTH_W-1:0]   m_reg, nmon_reg;
    logic [cdem_pkg::HOUR_W-1:0]    hour_reg;
    logic [cdem_pkg::MINUTE_W-1:0]  minute_reg;
    logic [cdem_pkg::SECOND_W-1:0]  second_reg;
    logic [DAYS_W-1:0]              days_reg;
    logic [ACC_W-1:0]               acc_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [cdem_pkg::EPOCH_W-1:0]   out_data_reg;

    logic [cdem_pkg::YEAR_W-1:0]    year_c;
    logic [cdem_pkg::MONTH_W-1:0]   nmon_c;
    logic                           target_leap, loop_leap;
    logic [DAYS_W-1:0]              mul_a;
    logic [26:0]                    mul_b;
    logic [ACC_W-1:0]               prod;
    logic [ACC_W-1:0]               res;
    logic [63:0]                    res64;

    always_comb begin
        year_c = (s_year > YEAR_CAP_V) ? YEAR_CAP_V : s_year;
        if (s_month == '0) begin
            nmon_c = '0;
        end else if (s_month > cdem_pkg::MONTHS_PER_YEAR) begin
            nmon_c = cdem_pkg::MONTHS_PER_YEAR;
        end else begin
            nmon_c = s_month - 4'd1;
        end
    end

    assign target_leap = cdem_pkg::leap_from_mod400(r_reg[8:0]);
    assign loop_leap   = cdem_pkg::leap_from_mod400(c400_reg);

    always_comb begin
        unique case (cmd.scale_sel)
            cdem_pkg::SC_DAY: begin
                mul_a = days_reg;
                mul_b = cdem_pkg::MS_PER_DAY;
            end
            cdem_pkg::SC_HOUR: begin
                mul_a = DAYS_W'(hour_reg);
                mul_b = cdem_pkg::MS_PER_HOUR;
            end
            cdem_pkg::SC_MIN: begin
                mul_a = DAYS_W'(minute_reg);
                mul_b = cdem_pkg::MS_PER_MIN;
            end
            cdem_pkg::SC_SEC: begin
                mul_a = DAYS_W'(second_reg);
                mul_b = cdem_pkg::MS_PER_SEC;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = ACC_W'(mul_a) * ACC_W'(mul_b);

    // day count includes the one-based day-of-month offset; one day is taken off here, clamped at zero
    assign res   = (acc_reg < ACC_W'(cdem_pkg::MS_PER_DAY)) ? '0
                 : acc_reg - ACC_W'(cdem_pkg::MS_PER_DAY);
    assign res64 = 64'(res);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            year_reg   <= year_c;
            r_reg      <= year_c;
            y_reg      <= BASE_YEAR_V;
            c400_reg   <= cdem_pkg::BASE_MOD400;
            m_reg      <= '0;
            nmon_reg   <= nmon_c;
            hour_reg   <= s_hour;
            minute_reg <= s_minute;
            second_reg <= s_second;
            days_reg   <= DAYS_W'(s_day);
        end
        if (cmd.leap_step) begin
            r_reg <= r_reg - CYCLE_V;
        end
        if (cmd.year_step) begin
            days_reg <= days_reg + (loop_leap ? DAYS_W'(cdem_pkg::DAYS_LEAP)
                                              : DAYS_W'(cdem_pkg::DAYS_COMMON));
            y_reg    <= y_reg + 12'd1;
            c400_reg <= (c400_reg == cdem_pkg::MOD400_LAST) ? 9'd0 : c400_reg + 9'd1;
        end
        if (cmd.month_step) begin
            days_reg <= days_reg + DAYS_W'(cdem_pkg::month_len(m_reg, target_leap));
            m_reg    <= m_reg + 4'd1;
        end
        if (cmd.scale_step) begin
            acc_reg <= (cmd.scale_sel == cdem_pkg::SC_DAY) ? prod : acc_reg + prod;
        end
        if (cmd.finish) begin
            out_data_reg <= res64[cdem_pkg::EPOCH_W-1:0];
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.leap_done   = (r_reg < CYCLE_V);
    assign status.years_done  = (y_reg >= year_reg);
    assign status.months_done = (m_reg >= nmon_reg);
    assign status.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid   = out_valid_reg;
    assign m_epoch_ms = out_data_reg;

    `ASSERT_CLK_RST(a_finish_no_overwrite, aclk, aresetn, cmd.finish |-> (!out_valid_reg || m_tready))
    `ASSERT_CLK_RST(a_months_use_reduced_year, aclk, aresetn, cmd.month_step |-> (r_reg < CYCLE_V))
    `ASSERT_CLK_RST(a_scale_after_months, aclk, aresetn, (cmd.scale_step && (cmd.scale_sel == cdem_pkg::SC_DAY)) |-> (m_reg >= nmon_reg) && (y_reg >= year_reg))
    `ASSERT_RESET_CLEARS(a_reset_clears_valid, aclk, aresetn, out_valid_reg)

endmodule

// ----- hw/rtl/calendar_date_to_epoch_ms_unit.sv -----
// Channel   Dir  Beat content (tdata, low bit first)
// s_        in   year[11:0] month[15:12] day[20:16] hour[25:21] minute[31:26] second[37:32]
// m_        out  epoch_ms[42:0]
//
// Steps per beat: accept, leap reduction (Y reduced mod 400), year loop (1970 up to Y-1),
//   month loop (months before), 4 scaling steps, result write; Y = clamped year.
//   The year loop dominates for late years.
// One beat in flight; a new beat is taken while the previous result sits in the output register.
// A result held by m_tready low stalls only the final write of the next beat.
// aresetn is synchronous, active low; it clears the sequencer and the output valid.
// Top level: instantiates cdem_ctrl and cdem_dp; depends on cdem_pkg.
`timescale 1ns / 1ps

module calendar_date_to_epoch_ms_unit #(
    parameter int LAST_YEAR = 2225
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // year[11:0], month[15:12], day[20:16], hour[25:21],
                                   // minute[31:26], second[37:32], zero pad[39:38]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // epoch_ms[42:0], zero pad[47:43]
);

    cdem_pkg::dp_cmd_t              cmd;
    cdem_pkg::dp_status_t           status;
    logic [cdem_pkg::EPOCH_W-1:0]   epoch_ms;

    cdem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cdem_dp #(
        .LAST_YEAR (LAST_YEAR)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_year     (s_tdata[11:0]),
        .s_month    (s_tdata[15:12]),
        .s_day      (s_tdata[20:16]),
        .s_hour     (s_tdata[25:21]),
        .s_minute   (s_tdata[31:26]),
        .s_second   (s_tdata[37:32]),
        .cmd        (cmd),
        .status     (status),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_epoch_ms (epoch_ms)
    );

    assign m_tdata = {5'b0, epoch_ms};

endmodule
